// ----- hdl/escf_pkg.sv -----
package escf_pkg;

	localparam int FIT_SPAN_DEF      = 10;
	localparam int MAX_ROW_WIDTH_DEF = 4096;
	localparam int PIXEL_BITS_DEF    = 16;

	localparam int FRAC_BITS     = 16;
	localparam int CONTRAST_BITS = 24;
	// quotient bits kept before the rounding halving
	localparam int QUO_BITS      = CONTRAST_BITS + 1;
	// magnitude bits that enter the divider below the initial remainder
	localparam int LOW_BITS      = QUO_BITS - FRAC_BITS - 1;

	typedef struct packed {
		logic                     invalid;
		logic [CONTRAST_BITS-1:0] contrast;
	} div_result_t;

	// integer fit weight at distance q from the edge, common scale removed
	function automatic int fit_weight(input int n, input int q);
		return (n * n - 1) + 3 * n * (n - 1 - 2 * q);
	endfunction

	function automatic int weight_width(input int n);
		return $clog2(4 * n * n) + 1;
	endfunction

	// signed width of one extrapolation sum
	function automatic int acc_width(input int n, input int pb);
		int s;
		int w;
		s = 0;
		for (int q = 0; q < n; q++) begin
			w = fit_weight(n, q);
			s += (w < 0) ? -w : w;
		end
		return pb + $clog2(s + 1) + 1;
	endfunction

endpackage

// ----- hdl/escf_dot.sv -----
module escf_dot #(
	parameter int N  = escf_pkg::FIT_SPAN_DEF,
	parameter int PB = escf_pkg::PIXEL_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [2*N-1:0][PB-1:0]                      win,
	output logic                                        done,
	output logic signed [escf_pkg::acc_width(N,PB)-1:0] v1,
	output logic signed [escf_pkg::acc_width(N,PB)-1:0] v2
);

	localparam int VW   = escf_pkg::acc_width(N, PB);
	localparam int WW   = escf_pkg::weight_width(N);
	localparam int PW   = WW + PB + 1;
	localparam int CNTW = $clog2(N);
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(N - 1);

	logic [N-1:0][PB-1:0] left_q;
	logic [N-1:0][PB-1:0] right_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic signed [VW-1:0] acc1_q;
	logic signed [VW-1:0] acc2_q;
	logic signed [WW-1:0] w;
	logic signed [PW-1:0] p1;
	logic signed [PW-1:0] p2;

	assign w  = WW'(escf_pkg::fit_weight(N, int'(cnt_q)));
	assign p1 = PW'(w) * PW'($signed({1'b0, left_q[0]}));
	assign p2 = PW'(w) * PW'($signed({1'b0, right_q[0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// taps leave the snapshot nearest to the edge first
	always_ff @(posedge clk) begin
		if (start) begin
			acc1_q <= '0;
			acc2_q <= '0;
			for (int q = 0; q < N; q++) begin
				left_q[q]  <= win[N+q];
				right_q[q] <= win[N-1-q];
			end
		end else if (busy_q) begin
			acc1_q  <= acc1_q + VW'(p1);
			acc2_q  <= acc2_q + VW'(p2);
			left_q  <= {{PB{1'b0}}, left_q[N-1:1]};
			right_q <= {{PB{1'b0}}, right_q[N-1:1]};
		end
	end

	assign done = done_q;
	assign v1   = acc1_q;
	assign v2   = acc2_q;

endmodule

// ----- hdl/escf_div.sv -----
module escf_div #(
	parameter int N  = escf_pkg::FIT_SPAN_DEF,
	parameter int PB = escf_pkg::PIXEL_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic signed [escf_pkg::acc_width(N,PB)-1:0] v1,
	input  logic signed [escf_pkg::acc_width(N,PB)-1:0] v2,
	output logic                                        done,
	output escf_pkg::div_result_t                       res
);

	localparam int VW = escf_pkg::acc_width(N, PB);
	localparam int SW = VW + 2;
	localparam int RW = SW + 1;
	localparam int QW = escf_pkg::QUO_BITS;
	localparam int LB = escf_pkg::LOW_BITS;
	localparam int FB = escf_pkg::FRAC_BITS;
	localparam int CB = escf_pkg::CONTRAST_BITS;
	localparam int IW = $clog2(QW);
	localparam logic [IW-1:0] IT_LAST = IW'(QW - 1);
	localparam logic [QW-1:0] LIM_NEG = QW'(2 ** (CB - 1));
	localparam logic [QW-1:0] LIM_POS = QW'(2 ** (CB - 1) - 1);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_FLIP = 3'd1;
	localparam logic [2:0] PH_ABS  = 3'd2;
	localparam logic [2:0] PH_ITER = 3'd3;
	localparam logic [2:0] PH_FIN  = 3'd4;

	logic [2:0]           ph_q;
	logic [IW-1:0]        it_q;
	logic                 done_q;
	logic signed [SW-1:0] num_q;
	logic signed [SW-1:0] den_q;
	logic [SW-1:0]        dabs_q;
	logic [RW-1:0]        r_q;
	logic [QW-1:0]        sh_q;
	logic [QW-1:0]        quo_q;
	logic                 neg_q;
	logic                 zero_q;
	logic                 ovf_q;
	escf_pkg::div_result_t res_q;

	logic [SW-1:0] mag;
	logic [RW-1:0] r0;
	logic          zero;
	logic          ovf;
	logic [RW-1:0] rs;
	logic          ge;
	logic [QW-1:0] qr;
	logic [QW-1:0] m;
	logic [CB-1:0] c;

	assign mag  = num_q[SW-1] ? SW'(-num_q) : SW'(num_q);
	assign r0   = RW'(mag >> LB);
	assign zero = (den_q == '0);
	assign ovf  = (r0 >= RW'(den_q));

	assign rs = {r_q[RW-2:0], sh_q[QW-1]};
	assign ge = (rs >= RW'(dabs_q));

	always_comb begin
		qr = QW'(({1'b0, quo_q} + (QW+1)'(1)) >> 1);
		if (neg_q) begin
			m = (ovf_q || qr > LIM_NEG) ? LIM_NEG : qr;
			c = CB'(-m);
		end else begin
			m = (ovf_q || qr > LIM_POS) ? LIM_POS : qr;
			c = CB'(m);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			it_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					if (start) ph_q <= PH_FLIP;
				end
				PH_FLIP: begin
					ph_q <= PH_ABS;
				end
				PH_ABS: begin
					it_q <= '0;
					ph_q <= (zero || ovf) ? PH_FIN : PH_ITER;
				end
				PH_ITER: begin
					it_q <= it_q + IW'(1);
					if (it_q == IT_LAST) ph_q <= PH_FIN;
				end
				PH_FIN: begin
					done_q <= 1'b1;
					ph_q   <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			PH_IDLE: begin
				if (start) begin
					num_q <= SW'(v1) - SW'(v2);
					den_q <= SW'(v1) + SW'(v2);
				end
			end
			PH_FLIP: begin
				if (den_q[SW-1]) begin
					num_q <= -num_q;
					den_q <= -den_q;
				end
			end
			PH_ABS: begin
				neg_q  <= num_q[SW-1];
				dabs_q <= SW'(den_q);
				zero_q <= zero;
				ovf_q  <= ovf;
				r_q    <= r0;
				sh_q   <= {mag[LB-1:0], (FB+1)'(0)};
				quo_q  <= '0;
			end
			PH_ITER: begin
				r_q   <= ge ? rs - RW'(dabs_q) : rs;
				sh_q  <= {sh_q[QW-2:0], 1'b0};
				quo_q <= {quo_q[QW-2:0], ge};
			end
			PH_FIN: begin
				res_q.invalid  <= zero_q;
				res_q.contrast <= zero_q ? '0 : c;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- hdl/edge_step_contrast_filter.sv -----
// channel | valid     | stall     | fields
// --------+-----------+-----------+----------------------------
// pixel   | pix_valid | pix_stall | pixel, row_end
// result  | res_valid | res_stall | contrast, invalid, row_done
//
// A result word passes through load, the two-tap MAC, the radix-2 divider,
// hand-off and advance. A pixel that closes a column starts that pass; one
// that closes no column goes straight to advance. The row end adds up to
// FIT_SPAN - 1 flushed results, pix_stall high.
// Reset clears the window and column count at once; no clearing pass.
// A held result word leaves the input side free until the next result is ready.
module edge_step_contrast_filter #(
	parameter int FIT_SPAN      = escf_pkg::FIT_SPAN_DEF,
	parameter int MAX_ROW_WIDTH = escf_pkg::MAX_ROW_WIDTH_DEF,
	parameter int PIXEL_BITS    = escf_pkg::PIXEL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pix_valid,
	output logic                                  pix_stall,
	input  logic [PIXEL_BITS-1:0]                 pixel,
	input  logic                                  row_end,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic signed [escf_pkg::CONTRAST_BITS-1:0] contrast,
	output logic                                  invalid,
	output logic                                  row_done
);

	localparam int N    = FIT_SPAN;
	localparam int PB   = PIXEL_BITS;
	localparam int VW   = escf_pkg::acc_width(N, PB);
	localparam int CW   = $clog2(MAX_ROW_WIDTH + 1);
	localparam int JW   = $clog2(N);
	localparam int SUMW = CW + 2;
	localparam int CB   = escf_pkg::CONTRAST_BITS;
	localparam logic [JW-1:0] J_LAST  = JW'(N - 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ROW_WIDTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DOT  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_PUT  = 3'd4;
	localparam logic [2:0] ST_ADV  = 3'd5;

	logic [2:0]             state_q;
	logic [2*N-1:0][PB-1:0] win_q;
	logic [CW-1:0]          count_q;
	logic [JW-1:0]          j_q;
	logic                   last_q;
	logic                   res_valid_q;
	logic [CB-1:0]          contrast_q;
	logic                   invalid_q;
	logic                   row_done_q;

	logic [CW-1:0]        cnt_new;
	logic                 new_emit;
	logic                 adv_emit;
	logic                 out_free;
	logic                 dot_start;
	logic                 dot_done;
	logic signed [VW-1:0] v1;
	logic signed [VW-1:0] v2;
	logic                 div_start;
	logic                 div_done;
	escf_pkg::div_result_t div_res;

	assign cnt_new   = (count_q == CNT_MAX) ? count_q : count_q + CW'(1);
	assign new_emit  = SUMW'(cnt_new) >= SUMW'(N);
	assign adv_emit  = (SUMW'(count_q) + SUMW'(j_q) + SUMW'(1)) >= SUMW'(N);
	assign out_free  = !res_valid_q || !res_stall;
	assign dot_start = (state_q == ST_LOAD);
	assign div_start = (state_q == ST_DOT) && dot_done;
	assign pix_stall = (state_q != ST_IDLE);

	escf_dot #(.N(N), .PB(PB)) u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dot_start),
		.win    (win_q),
		.done   (dot_done),
		.v1     (v1),
		.v2     (v2)
	);

	escf_div #(.N(N), .PB(PB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.v1     (v1),
		.v2     (v2),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= '0;
			count_q     <= '0;
			j_q         <= '0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PUT && out_free) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pix_valid) begin
						win_q   <= {win_q[2*N-2:0], pixel};
						count_q <= cnt_new;
						last_q  <= row_end;
						j_q     <= '0;
						state_q <= new_emit ? ST_LOAD : ST_ADV;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DOT;
				end
				ST_DOT: begin
					if (dot_done) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_free) state_q <= ST_ADV;
				end
				ST_ADV: begin
					if (last_q && j_q != J_LAST) begin
						// flush: zeros past the row end
						win_q   <= {win_q[2*N-2:0], {PB{1'b0}}};
						j_q     <= j_q + JW'(1);
						state_q <= adv_emit ? ST_LOAD : ST_ADV;
					end else begin
						if (last_q) begin
							win_q   <= '0;
							count_q <= '0;
							j_q     <= '0;
							last_q  <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUT && out_free) begin
			contrast_q <= div_res.contrast;
			invalid_q  <= div_res.invalid;
			row_done_q <= last_q && (j_q == J_LAST);
		end
	end

	assign res_valid = res_valid_q;
	assign contrast  = contrast_q;
	assign invalid   = invalid_q;
	assign row_done  = row_done_q;

	a_flush_bound: assert property (@(posedge clk) disable iff (!arst_n)
		j_q <= J_LAST)
		else $error("flush step past the window");

	a_flush_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!last_q |-> (j_q == '0))
		else $error("flush step outside a row end");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("column count past saturation");

	a_dot_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		dot_done |-> (state_q == ST_DOT))
		else $error("dot product finished outside its wait state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

endmodule

// ----- test/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPAN         = escf_pkg::FIT_SPAN_DEF;
	localparam int WIN          = 2 * SPAN;
	localparam int PIX_W        = escf_pkg::PIXEL_BITS_DEF;
	localparam int C_BITS       = escf_pkg::CONTRAST_BITS;
	localparam int FRAC         = escf_pkg::FRAC_BITS;
	// small column ceiling so an overlong row fits in a short run
	localparam int ROW_CAP      = 32;
	localparam longint C_HI     = (longint'(1) << (C_BITS - 1)) - 1;
	localparam longint C_LO_MAG = longint'(1) << (C_BITS - 1);
	localparam int RANDOM_ITEMS = 380;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PRINT_CAP    = 40;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;
	typedef enum int {ROW_NOISE, ROW_STEP, ROW_DIM, ROW_BITS, ROW_FLAT} row_style_t;

	typedef struct {
		logic signed [C_BITS-1:0] contrast;
		logic                     invalid;
		logic                     row_done;
	} result_word_t;

	typedef struct {
		logic [PIX_W-1:0] value;
		logic             last;
		bit               drain_first;
	} pixel_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     pix_valid = 1'b0;
	logic                     pix_stall;
	logic [PIX_W-1:0]         pixel = '0;
	logic                     row_end = 1'b0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	logic signed [C_BITS-1:0] contrast;
	logic                     invalid;
	logic                     row_done;

	pixel_word_t  pixel_feed[$];
	result_word_t expected_words[$];

	bit [PIX_W-1:0] edge_window[WIN];
	int             row_fill;

	int items_total;
	int items_accepted;
	int words_predicted;
	int words_checked;
	int rows_done;
	int longest_row;
	int invalid_seen;
	int saturated_seen;
	int mismatches;
	int cycle_count;

	int          burst_left;
	int          gap_left;
	stall_mode_t stall_mode;
	int          mode_left;
	int          phase;
	int          run_left;
	bit          long_on;

	edge_step_contrast_filter #(.MAX_ROW_WIDTH(ROW_CAP)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel    (pixel),
		.row_end  (row_end),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.contrast (contrast),
		.invalid  (invalid),
		.row_done (row_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// both line fits extrapolated to the edge, then (v1-v2)/(v1+v2) in Q8.16
	function automatic result_word_t column_contrast();
		result_word_t      r;
		longint            v_left;
		longint            v_right;
		longint            w;
		longint            num;
		longint            den;
		longint unsigned   den_u;
		longint unsigned   mag;
		longint unsigned   quo;
		int                q;
		v_left = 0;
		v_right = 0;
		for (q = 0; q < SPAN; q++) begin
			w = SPAN * SPAN - 1 + 3 * SPAN * (SPAN - 1 - 2 * q);
			v_left += w * longint'(edge_window[SPAN + q]);
			v_right += w * longint'(edge_window[SPAN - 1 - q]);
		end
		num = v_left - v_right;
		den = v_left + v_right;
		r.row_done = 1'b0;
		if (den == 0) begin
			r.contrast = '0;
			r.invalid = 1'b1;
			return r;
		end
		r.invalid = 1'b0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		den_u = den;
		mag = (num < 0) ? -num : num;
		quo = ((mag << (FRAC + 1)) + den_u) / (den_u << 1);
		if (num < 0) begin
			if (quo > C_LO_MAG)
				quo = C_LO_MAG;
			r.contrast = C_BITS'(-quo);
		end else begin
			if (quo > C_HI)
				quo = C_HI;
			r.contrast = C_BITS'(quo);
		end
		return r;
	endfunction

	task automatic shift_pixel(input logic [PIX_W-1:0] v);
		int i;
		for (i = WIN - 1; i > 0; i--)
			edge_window[i] = edge_window[i - 1];
		edge_window[0] = v;
	endtask

	task automatic take_pixel(input logic [PIX_W-1:0] v, input logic last);
		int j;
		int made;
		made = 0;
		shift_pixel(v);
		if (row_fill < ROW_CAP)
			row_fill++;
		if (row_fill >= SPAN) begin
			expected_words.push_back(column_contrast());
			made++;
		end
		if (last) begin
			// flush: zeros stand in past the row end
			for (j = 1; j < SPAN; j++) begin
				shift_pixel('0);
				if (row_fill + j >= SPAN) begin
					expected_words.push_back(column_contrast());
					made++;
				end
			end
			if (made > 0)
				expected_words[expected_words.size() - 1].row_done = 1'b1;
			for (j = 0; j < WIN; j++)
				edge_window[j] = '0;
			row_fill = 0;
			rows_done++;
		end
		words_predicted += made;
	endtask

	task automatic add_row(input int width, input row_style_t style, input bit drain_first);
		int               i;
		int               edge_at;
		logic [PIX_W-1:0] lo;
		logic [PIX_W-1:0] hi;
		logic [PIX_W-1:0] v;
		edge_at = $urandom_range(0, width);
		lo = PIX_W'($urandom);
		hi = PIX_W'($urandom);
		for (i = 0; i < width; i++) begin
			case (style)
				ROW_NOISE: v = PIX_W'($urandom);
				ROW_STEP: v = (i < edge_at ? lo : hi) ^ PIX_W'($urandom_range(0, 7));
				ROW_DIM: v = ($urandom_range(0, 3) == 0) ? '0 : PIX_W'($urandom_range(0, 15));
				ROW_BITS: begin
					v = PIX_W'(1) << $urandom_range(0, PIX_W - 1);
					if ($urandom_range(0, 1))
						v = ~v;
				end
				default: v = lo;
			endcase
			pixel_feed.push_back('{v, i == width - 1, drain_first && i == 0});
		end
		if (width > longest_row)
			longest_row = width;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_CAP)
			$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// pixel driver: bursts with random gaps, optional wait for a full drain
	always @(posedge clk or negedge arst_n) begin
		pixel_word_t next_word;
		bit          busy;
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pixel <= '0;
			row_end <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			busy = pix_valid;
			if (pix_valid && !pix_stall) begin
				take_pixel(pixel, row_end);
				items_accepted++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
					pix_valid <= 1'b0;
				end else if (pixel_feed.size() != 0 &&
						(!pixel_feed[0].drain_first || words_checked == words_predicted)) begin
					next_word = pixel_feed.pop_front();
					pixel <= next_word.value;
					row_end <= next_word.last;
					pix_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		bit           stall_next;
		if (!arst_n) begin
			res_stall <= 1'b0;
			mode_left = 0;
			run_left = 0;
			long_on = 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result word with nothing expected", contrast, 0);
				end else begin
					want = expected_words.pop_front();
					if (contrast !== want.contrast)
						report_mismatch("contrast", contrast, want.contrast);
					if (invalid !== want.invalid)
						report_mismatch("invalid", invalid, want.invalid);
					if (row_done !== want.row_done)
						report_mismatch("row_done", row_done, want.row_done);
					if (want.invalid)
						invalid_seen++;
					if (longint'(want.contrast) == C_HI || longint'(want.contrast) == -C_LO_MAG)
						saturated_seen++;
				end
				words_checked <= words_checked + 1;
			end
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 400);
				phase = 0;
			end
			mode_left--;
			phase++;
			case (stall_mode)
				STALL_RANDOM: stall_next = ($urandom_range(0, 2) == 0);
				STALL_PERIODIC: stall_next = (phase % 7) < 3;
				STALL_LONG: begin
					if (run_left == 0) begin
						long_on = !long_on;
						run_left = long_on ? $urandom_range(10, 30) : $urandom_range(1, 8);
					end
					run_left--;
					stall_next = long_on;
				end
				default: stall_next = 1'b0;
			endcase
			res_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cycle limit reached, %0d words still expected", expected_words.size());
			$display("edge_step_contrast_filter test failed");
			$finish;
		end
	end

	initial begin
		int         i;
		int         fed;
		int         width;
		row_style_t style;

		// single-pixel row at full scale
		pixel_feed.push_back('{PIX_W'(65535), 1'b1, 1'b0});
		// far-left pixel against the edge pixel: weights nearly cancel, denominator
		// tiny, negative in the first row, positive in the second; both saturate
		for (i = 0; i < 2; i++) begin
			pixel_feed.push_back('{PIX_W'(i == 0 ? 370 : 368), 1'b0, 1'b0});
			repeat (SPAN - 3) pixel_feed.push_back('{PIX_W'(0), 1'b0, 1'b0});
			pixel_feed.push_back('{PIX_W'(51), 1'b1, 1'b0});
		end
		// dark row: zero denominator everywhere
		for (i = 0; i < 3; i++)
			pixel_feed.push_back('{PIX_W'(0), i == 2, 1'b0});
		longest_row = SPAN - 1;

		fed = 0;
		while (fed < RANDOM_ITEMS) begin
			width = ($urandom_range(0, 5) == 0) ? $urandom_range(31, 64) : $urandom_range(1, 30);
			style = row_style_t'($urandom_range(0, 4));
			add_row(width, style, fed == 0 || $urandom_range(0, 4) == 0);
			fed += width;
		end
		// overlong row runs the column count into its ceiling
		add_row(ROW_CAP + 12, ROW_STEP, 1'b1);
		items_total = pixel_feed.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_accepted < items_total || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d pixels in %0d rows (longest %0d), %0d result words checked",
			items_accepted, rows_done, longest_row, words_checked);
		$display("%0d invalid words, %0d saturated words, %0d mismatches",
			invalid_seen, saturated_seen, mismatches);
		if (mismatches == 0)
			$display("edge_step_contrast_filter test passed");
		else
			$display("edge_step_contrast_filter test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/escf_pkg.sv
hdl/escf_dot.sv
hdl/escf_div.sv
hdl/edge_step_contrast_filter.sv
test/testbench.sv
